### src/lts_pkg.sv
`default_nettype none

package lts_pkg;

  // Default length cap for a token; the counter never exceeds 127
  localparam int MAX_TOKEN_BYTES_DEF = 127;
  localparam int LEN_LIMIT           = 127;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Keywords packed as the first bytes of a token, first byte lowest
  localparam logic [31:0] KW_IF   = 32'h0000_6669;
  localparam logic [31:0] KW_ELSE = 32'h6573_6c65;

  typedef enum logic [2:0] {
    KIND_IDENT   = 3'd0,
    KIND_NUMBER  = 3'd1,
    KIND_OPER    = 3'd2,
    KIND_SPECIAL = 3'd3,
    KIND_KEYWORD = 3'd4,
    KIND_END     = 3'd5,
    KIND_UNKNOWN = 3'd6
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [6:0]  length;
    logic [31:0] start;
  } token_t;

  // One queue entry: all tokens caused by one input byte
  typedef struct packed {
    token_t a;
    logic   has_b;
    token_t b;
  } entry_t;

endpackage

`default_nettype wire

### src/lexical_token_scanner.sv
// Lexical token scanner.
// Input stream (s_*): one text byte per transfer in s_tdata[7:0]; s_tuser high
// marks end of text (the byte is then ignored). Output stream (m_*): one token
// per transfer, m_tuser holds the kind, m_tdata holds length [6:0] and start
// offset [38:7]; m_tlast marks the last token caused by one input byte.
// Throughput: one input byte per cycle. A byte that both ends a token and forms
// one (operator, special, end marker after pending text) yields two tokens and
// occupies the output for both; a 4-entry queue between the classifier and
// the output stage absorbs these, so input stalls only when it fills.
// With the output stage idle, the first token of a byte is written to the
// queue and then loaded into the output register; a second token follows once
// the first is taken, and tokens behind earlier queue entries wait their turn.
// Reset (rst, synchronous) clears the pending token, the byte offset and the
// queue. When the receiver holds m_tready low, tokens wait in the output
// register and the queue; s_tready drops once the queue is full.
`default_nettype none

module lexical_token_scanner
  import lts_pkg::*;
#(
  parameter int MAX_TOKEN_BYTES = MAX_TOKEN_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tuser,   // [0] end_of_input
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [6:0] token_length, [38:7] token_start,
                                      // [39] zero
  output logic [2:0]       m_tuser,   // [2:0] token_kind
  output logic             m_tlast    // last_of_run
);

  logic   q_full, q_push, q_empty, q_pop;
  entry_t q_wdata, q_rdata;

  lts_front #(
    .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_wdata)
  );

  lts_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push && s_tvalid && s_tready),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  lts_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

### src/lts_front.sv
`default_nettype none

module lts_front
  import lts_pkg::*;
#(
  parameter int MAX_TOKEN_BYTES = MAX_TOKEN_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tuser,   // [0] end_of_input
  input  wire logic       q_full,
  output logic            q_push,
  output entry_t          q_entry
);

  localparam int LEN_CAP = (MAX_TOKEN_BYTES > LEN_LIMIT) ? LEN_LIMIT : MAX_TOKEN_BYTES;
  localparam logic [6:0] CAP7 = 7'(LEN_CAP);

  logic [6:0]  pending_length, pending_length_next;
  logic [31:0] prefix_bytes, prefix_bytes_next;
  logic [2:0]  class_flags, class_flags_next;
  logic [31:0] pending_start, pending_start_next;
  logic [31:0] byte_offset, byte_offset_next;

  logic        accept;
  logic [7:0]  c;
  logic        c_digit, c_alpha, c_space, c_oper, c_special;
  logic        has_pend;
  tok_kind_t   pend_kind;
  token_t      pend_tok, end_tok, single_tok;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign c        = s_tdata;

  // Byte classes
  always_comb begin
    c_digit   = (c >= 8'h30) && (c <= 8'h39);
    c_alpha   = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
                (c == 8'h5f);
    c_space   = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    c_oper    = (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2a) || (c == 8'h2f) ||
                (c == 8'h25) || (c == 8'h3c) || (c == 8'h3d) || (c == 8'h3e);
    c_special = (c == 8'h28) || (c == 8'h29) || (c == 8'h7b) || (c == 8'h7d) ||
                (c == 8'h3b) || (c == 8'h3a) || (c == 8'h2c) || (c == 8'h27) ||
                (c == 8'h22);
  end

  // Class of the pending token
  always_comb begin
    if ((pending_length == 7'd2) && (prefix_bytes == KW_IF)) begin
      pend_kind = KIND_KEYWORD;
    end else if ((pending_length == 7'd4) && (prefix_bytes == KW_ELSE)) begin
      pend_kind = KIND_KEYWORD;
    end else if (class_flags[2]) begin
      pend_kind = KIND_UNKNOWN;
    end else if (class_flags[0]) begin
      pend_kind = KIND_NUMBER;
    end else if (class_flags[1]) begin
      pend_kind = KIND_IDENT;
    end else begin
      pend_kind = KIND_UNKNOWN;
    end
  end

  assign has_pend = (pending_length != 7'd0);

  always_comb begin
    pend_tok.kind     = pend_kind;
    pend_tok.length   = pending_length;
    pend_tok.start    = pending_start;
    end_tok.kind      = KIND_END;
    end_tok.length    = 7'd0;
    end_tok.start     = byte_offset;
    single_tok.kind   = c_oper ? KIND_OPER : KIND_SPECIAL;
    single_tok.length = 7'd1;
    single_tok.start  = byte_offset;
  end

  // Next state and queue entry
  always_comb begin
    pending_length_next = pending_length;
    prefix_bytes_next   = prefix_bytes;
    class_flags_next    = class_flags;
    pending_start_next  = pending_start;
    byte_offset_next    = byte_offset + 32'd1;
    q_push              = 1'b0;
    q_entry.a           = pend_tok;
    q_entry.has_b       = 1'b0;
    q_entry.b           = end_tok;

    if (s_tuser) begin
      // end marker: flush, end token, clear everything
      q_push              = 1'b1;
      q_entry.has_b       = has_pend;
      if (!has_pend) q_entry.a = end_tok;
      pending_length_next = '0;
      prefix_bytes_next   = '0;
      class_flags_next    = '0;
      pending_start_next  = '0;
      byte_offset_next    = '0;
    end else if (c_space) begin
      q_push              = has_pend;
      pending_length_next = '0;
      prefix_bytes_next   = '0;
      class_flags_next    = '0;
      pending_start_next  = '0;
    end else if (c_oper || c_special) begin
      q_push              = 1'b1;
      q_entry.has_b       = has_pend;
      q_entry.b           = single_tok;
      if (!has_pend) q_entry.a = single_tok;
      pending_length_next = '0;
      prefix_bytes_next   = '0;
      class_flags_next    = '0;
      pending_start_next  = '0;
    end else begin
      // append to pending token
      if (!has_pend) begin
        pending_start_next = byte_offset;
        prefix_bytes_next  = {24'd0, c};
        class_flags_next   = {1'b0, c_alpha && !c_digit, c_digit};
      end else begin
        if (pending_length < 7'd4) begin
          prefix_bytes_next[{pending_length[1:0], 3'b000} +: 8] = c;
        end
        class_flags_next[2] = class_flags[2] ||
                              (class_flags[0] && !c_digit) ||
                              (class_flags[1] && !c_digit && !c_alpha);
      end
      if (pending_length < CAP7) pending_length_next = pending_length + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_length <= '0;
      prefix_bytes   <= '0;
      class_flags    <= '0;
      pending_start  <= '0;
      byte_offset    <= '0;
    end else if (accept) begin
      pending_length <= pending_length_next;
      prefix_bytes   <= prefix_bytes_next;
      class_flags    <= class_flags_next;
      pending_start  <= pending_start_next;
      byte_offset    <= byte_offset_next;
    end
  end

endmodule

`default_nettype wire

### src/lts_queue.sv
`default_nettype none

module lts_queue
  import lts_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr_en,
  input  entry_t      wr_data,
  output logic        full,
  input  wire logic   rd_en,
  output entry_t      rd_data,
  output logic        empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(QUEUE_DEPTH - 1);

  entry_t          mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr, do_rd;

  assign full    = (count == DEPTH_C);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == LAST_P) ? '0 : wr_ptr + PW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == LAST_P) ? '0 : rd_ptr + PW'(1);
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && full))
    else $error("queue written while full");

endmodule

`default_nettype wire

### src/lts_back.sv
`default_nettype none

module lts_back
  import lts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_empty,
  input  entry_t           q_data,
  output logic             q_pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // [6:0] token_length, [38:7] token_start,
                                     // [39] zero
  output logic [2:0]       m_tuser,  // [2:0] token_kind
  output logic             m_tlast   // last_of_run
);

  entry_t  rec;
  logic    busy;
  logic    phase;
  token_t  cur;
  logic    done;

  assign cur      = phase ? rec.b : rec.a;
  assign m_tvalid = busy;
  assign m_tlast  = phase || !rec.has_b;
  assign m_tdata  = {1'b0, cur.start, cur.length};
  assign m_tuser  = cur.kind;
  assign done     = busy && m_tready && m_tlast;
  assign q_pop    = !q_empty && (!busy || done);

  // Output record, one or two transfers per entry
  always_ff @(posedge clk) begin
    if (q_pop) rec <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (q_pop) begin
      busy  <= 1'b1;
      phase <= 1'b0;
    end else if (done) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (busy && m_tready) begin
      phase <= 1'b1;
    end
  end

  a_phase_needs_b: assert property (@(posedge clk) disable iff (rst)
    busy && phase |-> rec.has_b)
    else $error("second token sent from a single-token entry");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (cur.kind == KIND_END) |-> m_tlast)
    else $error("end token not last of run");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (cur.kind != KIND_END) |-> (cur.length != 7'd0))
    else $error("empty token sent");

endmodule

`default_nettype wire

### test/lexical_token_scanner_tb.sv
`timescale 1ns / 1ps

module lexical_token_scanner_tb;
  import lts_pkg::*;

  localparam int LEN_CAP     = (MAX_TOKEN_BYTES_DEF > LEN_LIMIT) ? LEN_LIMIT
                                                                 : MAX_TOKEN_BYTES_DEF;
  localparam int DRAIN_WAIT  = 12;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 2000;
  localparam int BLOCK_ITEMS = 250;

  localparam string LETTERS  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string DIGITS   = "0123456789";
  localparam string OPERS    = "+-*/%<=>";
  localparam string SPECIALS = "(){};:,'\"";
  localparam string BLANKS   = "\t\n\v\f\r ";

  typedef struct {
    tok_kind_t   kind;
    logic [6:0]  length;
    logic [31:0] start;
    bit          last;
  } token_rec_t;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_oper(logic [7:0] c);
    foreach (OPERS[i]) if (OPERS[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit is_special(logic [7:0] c);
    foreach (SPECIALS[i]) if (SPECIALS[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  // Tracks the pending token like the block does and queues the tokens due
  class token_board;
    token_rec_t  tokens_due[$];
    token_rec_t  fresh[$];
    logic [6:0]  run_len;
    logic [31:0] run_prefix;
    logic [31:0] run_start;
    logic [31:0] offset;
    bit          lead_digit;
    bit          lead_word;
    bit          mixed;
    int          errors;
    int          checked;

    function new();
      errors  = 0;
      checked = 0;
      offset  = '0;
      drop_run();
    endfunction

    function void drop_run();
      run_len    = '0;
      run_prefix = '0;
      run_start  = '0;
      lead_digit = 1'b0;
      lead_word  = 1'b0;
      mixed      = 1'b0;
    endfunction

    function tok_kind_t classify();
      if (run_len == 7'd2 && run_prefix == KW_IF) return KIND_KEYWORD;
      if (run_len == 7'd4 && run_prefix == KW_ELSE) return KIND_KEYWORD;
      if (mixed) return KIND_UNKNOWN;
      if (lead_digit) return KIND_NUMBER;
      if (lead_word) return KIND_IDENT;
      return KIND_UNKNOWN;
    endfunction

    function void add_token(tok_kind_t kind, logic [6:0] len, logic [31:0] start);
      token_rec_t rec;
      rec.kind   = kind;
      rec.length = len;
      rec.start  = start;
      rec.last   = 1'b0;
      fresh.push_back(rec);
    endfunction

    // Close the pending token, if any
    function void close_run();
      if (run_len == 0) return;
      add_token(classify(), run_len, run_start);
      drop_run();
    endfunction

    function void grow_run(logic [7:0] c);
      if (run_len == 0) begin
        run_start  = offset;
        run_prefix = {24'b0, c};
        lead_digit = is_digit(c);
        lead_word  = !is_digit(c) && is_word(c);
        mixed      = 1'b0;
      end else begin
        if (run_len < 4) run_prefix = run_prefix | ({24'b0, c} << (8 * run_len));
        if (lead_digit && !is_digit(c)) mixed = 1'b1;
        if (lead_word && !is_digit(c) && !is_word(c)) mixed = 1'b1;
      end
      if (run_len < LEN_CAP) run_len = run_len + 7'd1;
    endfunction

    // Called for every input transfer
    function void note_input(logic [7:0] c, logic eoi);
      token_rec_t rec;
      fresh.delete();
      if (eoi) begin
        close_run();
        add_token(KIND_END, 7'd0, offset);
        drop_run();
        offset = '0;
      end else begin
        if (is_blank(c)) begin
          close_run();
        end else if (is_oper(c) || is_special(c)) begin
          close_run();
          add_token(is_oper(c) ? KIND_OPER : KIND_SPECIAL, 7'd1, offset);
        end else begin
          grow_run(c);
        end
        offset = offset + 32'd1;
      end
      foreach (fresh[i]) begin
        rec = fresh[i];
        rec.last = (i == fresh.size() - 1);
        tokens_due.push_back(rec);
      end
    endfunction

    // Called for every output transfer
    function void check_token(logic [2:0] kind, logic [6:0] len, logic [31:0] start,
                              logic last);
      token_rec_t rec;
      if (tokens_due.size() == 0) begin
        $error("unexpected token: kind %0d length %0d start %0d", kind, len, start);
        errors++;
        return;
      end
      rec = tokens_due.pop_front();
      checked++;
      if (kind !== rec.kind) begin
        $error("token_kind: expected %0d, got %0d", rec.kind, kind);
        errors++;
      end
      if (len !== rec.length) begin
        $error("token_length: expected %0d, got %0d", rec.length, len);
        errors++;
      end
      if (start !== rec.start) begin
        $error("token_start: expected %0d, got %0d", rec.start, start);
        errors++;
      end
      if (last !== rec.last) begin
        $error("last_of_run: expected %0d, got %0d", rec.last, last);
        errors++;
      end
    endfunction

    function int waiting();
      return tokens_due.size();
    endfunction

    function void close_out();
      if (tokens_due.size() != 0) begin
        $error("%0d tokens never arrived", tokens_due.size());
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  token_board board;
  bit         tx_idle;
  bit         rx_idle;
  int         rx_stall;
  int         cycles;
  int         bytes_sent;
  int         ends_sent;
  int         longest;

  lexical_token_scanner u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stalls between transfers, checks at the rising edge
  initial begin
    m_tready = 1'b0;
    rx_stall = 0;
    forever begin
      @(negedge clk);
      if (rx_stall > 0) begin
        m_tready = 1'b0;
        rx_stall--;
      end else begin
        m_tready = 1'b1;
      end
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        board.check_token(m_tuser, m_tdata[6:0], m_tdata[38:7], m_tlast);
        rx_stall = rx_idle ? $urandom_range(0, 10) : 0;
      end
    end
  end

  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // A byte outside every class: not letter, digit, blank, operator or special
  function automatic logic [7:0] odd_byte();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (is_word(c) || is_digit(c) || is_blank(c) || is_oper(c) || is_special(c));
    return c;
  endfunction

  // Entered and left at a falling edge
  task automatic send_item(logic [7:0] c, logic eoi);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = c;
    s_tuser  = eoi;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_input(c, eoi);
    if (eoi) ends_sent++;
    else bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_item(s[i], 1'b0);
  endtask

  // Hold the input until every token has come out
  task automatic drain();
    s_tvalid = 1'b0;
    while (board.waiting() > 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // One random word or end marker plus an optional blank run
  task automatic send_word();
    logic [7:0] spell[$];
    string      near[9];
    string      word;
    int         choice;
    int         n;
    near = '{"iff", "els", "elsee", "i", "e", "If", "ELSE", "eLse", "el"};
    choice = $urandom_range(0, 199);
    if (choice < 24) begin
      if ($urandom_range(0, 1)) spell = '{"i", "f"};
      else spell = '{"e", "l", "s", "e"};
    end else if (choice < 40) begin
      n = $urandom_range(0, 8);
      word = near[n];
      foreach (word[i]) spell.push_back(word[i]);
    end else if (choice < 76) begin
      n = $urandom_range(1, 8);
      repeat (n) spell.push_back(pick(DIGITS));
    end else if (choice < 116) begin
      spell.push_back(pick(LETTERS));
      n = $urandom_range(0, 9);
      repeat (n) spell.push_back($urandom_range(0, 3) == 0 ? pick(DIGITS) : pick(LETTERS));
    end else if (choice < 132) begin
      // class broken by a later byte, unless a letter leads and no odd byte follows
      spell.push_back($urandom_range(0, 1) ? pick(DIGITS) : pick(LETTERS));
      repeat ($urandom_range(0, 3)) spell.push_back(pick(DIGITS));
      spell.push_back($urandom_range(0, 1) ? pick(LETTERS) : odd_byte());
      repeat ($urandom_range(0, 3)) spell.push_back(pick(LETTERS));
    end else if (choice < 144) begin
      spell.push_back(odd_byte());
      repeat ($urandom_range(0, 3)) spell.push_back(pick(LETTERS));
    end else if (choice < 168) begin
      spell.push_back(pick(OPERS));
    end else if (choice < 188) begin
      spell.push_back(pick(SPECIALS));
    end else if (choice < 194) begin
      repeat ($urandom_range(1, 3)) spell.push_back(8'($urandom_range(0, 255)));
    end else if (choice < 195) begin
      // long token around the length cap
      n = $urandom_range(LEN_CAP - 3, LEN_CAP + 12);
      if ($urandom_range(0, 1)) begin
        repeat (n) spell.push_back(pick(DIGITS));
      end else begin
        spell.push_back(pick(LETTERS));
        repeat (n - 1) spell.push_back(pick(LETTERS));
      end
      if (n > longest) longest = n;
    end else begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
    foreach (spell[i]) send_item(spell[i], 1'b0);
    if ($urandom_range(0, 9) < 6) begin
      repeat ($urandom_range(1, 2)) send_item(pick(BLANKS), 1'b0);
    end
  endtask

  initial begin
    int block;
    board      = new();
    cycles     = 0;
    bytes_sent = 0;
    ends_sent  = 0;
    longest    = 0;
    tx_idle    = 1'b0;
    rx_idle    = 1'b0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = 8'h00;
    s_tuser    = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: every token kind, edge bytes, end marker with and without text
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_text("if(");
    send_text("else=");
    send_text("09a\t");
    send_text("_Z9\n");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(" ", 1'b0);
    send_item("7", 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    drain();

    // Random: blocks with different idle patterns on each side
    block = 0;
    while (bytes_sent + ends_sent < ITEM_TARGET) begin
      tx_idle = (block == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
      rx_idle = (block == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
      while (bytes_sent + ends_sent < (block + 1) * BLOCK_ITEMS + 23) send_word();
      if (block % 3 == 1) drain();
      block++;
    end

    send_item(8'h00, 1'b1);
    drain();
    board.close_out();

    $display("sent %0d text bytes and %0d end markers, longest token %0d bytes",
             bytes_sent, ends_sent, longest);
    $display("checked %0d tokens in %0d cycles", board.checked, cycles);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
